// ===== design/mbe_pkg.sv =====
package mbe_pkg;

  localparam int CH_W         = 5;
  localparam int SAMPLE_W     = 17;
  localparam int COEF_W       = 26;
  localparam int OUT_W        = 18;
  localparam int AMP_W        = 17;
  localparam int PROD_W       = COEF_W + OUT_W;
  localparam int ACC_W        = 48;
  localparam int SQ_W         = 2 * OUT_W;
  localparam int CFG_IDX_W    = 3;
  localparam int S_DATA_W     = 24;
  localparam int M_DATA_W     = 40;
  localparam int CHANNELS_DEF = 32;

  localparam logic [SAMPLE_W-1:0] SAMPLE_ONE = SAMPLE_W'(65536);
  localparam logic [AMP_W-1:0]    AMP_MAX    = AMP_W'(65536);
  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 18'sh20000;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_RND,
    ST_SQR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        [SAMPLE_W-1:0] prev_input;
    logic        [SAMPLE_W-1:0] older_input;
    logic signed [OUT_W-1:0]    prev_output;
    logic signed [OUT_W-1:0]    older_output;
  } hist_t;

  function automatic logic [AMP_W-1:0] amp_of(input logic [SQ_W-1:0] sq);
    logic [SQ_W:0]     sum;
    logic [SQ_W-18:0]  raw;
    sum = {1'b0, sq} + (SQ_W + 1)'(1 << 17);
    raw = sum[SQ_W:18];
    if (raw > (SQ_W - 17)'(AMP_MAX)) begin
      return AMP_MAX;
    end
    return raw[AMP_W-1:0];
  endfunction

endpackage

// ===== design/multichannel_biquad_envelope_top.sv =====
// One item at a time: the block takes no new item until the last is written back.
// One shared 26x18 multiplier forms the five products in turn, then the sum,
// round, square and write-back states follow, and the idle state accepts the
// next item. A result still held on the master side stalls
// write-back until it is taken.
// An item whose channel is not below CHANNELS is accepted in the idle state and gives no result.
// Reset (rst, synchronous): coefficients to zero, history reads as zero
// through per-channel valid flags cleared at once, no clearing pass.
module multichannel_biquad_envelope_top #(
  parameter int CHANNELS = mbe_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [4:0] channel, [21:5] sample, [23:22] zero
  input  logic [mbe_pkg::S_DATA_W-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [4:0] out_channel, [22:5] filtered, [39:23] amplitude
  output logic [mbe_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::COEF_W-1:0]     cfg_data
);
  import mbe_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  state_t state, state_next;

  logic [CH_W-1:0]     in_channel;
  logic [SAMPLE_W-1:0] in_sample;
  logic [6:0]          in_ch_ext;
  logic                ch_ok;
  logic                accept;
  logic                out_load;

  logic [CH_W-1:0]     ch;
  logic [IDX_W-1:0]    idx;
  logic [SAMPLE_W-1:0] x;
  logic [2:0]          cnt;

  hist_t               mem [CHANNELS];
  logic [CHANNELS-1:0] ent_vld;
  hist_t               rd_data;
  logic                rd_vld;
  hist_t               hist;
  hist_t               wr_data;

  logic signed [COEF_W-1:0] coef_sel;
  logic signed [OUT_W-1:0]  op_sel;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic                     prod_sub;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [ACC_W-23:0] q;
  logic signed [OUT_W-1:0]  y;
  logic signed [OUT_W-1:0]  y_next;
  logic signed [SQ_W-1:0]   sq;

  logic                out_valid;
  logic [CH_W-1:0]     out_channel;
  logic signed [OUT_W-1:0] filtered;
  logic [AMP_W-1:0]    amplitude;

  assign in_channel = s_axis_tdata[CH_W-1:0];
  assign in_sample  = s_axis_tdata[CH_W+SAMPLE_W-1:CH_W];
  assign in_ch_ext  = 7'(in_channel);
  assign ch_ok      = in_ch_ext < 7'(CHANNELS);
  assign accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= '0;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:  coef_b0 <= cfg_data;
        REG_B1:  coef_b1 <= cfg_data;
        REG_B2:  coef_b2 <= cfg_data;
        REG_A1:  coef_a1 <= cfg_data;
        REG_A2:  coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && ch_ok) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (cnt == 3'd4) state_next = ST_SUM;
      end
      ST_SUM:  state_next = ST_RND;
      ST_RND:  state_next = ST_SQR;
      ST_SQR:  state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_DONE: out_load = !out_valid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch      <= in_channel;
      idx     <= in_ch_ext[IDX_W-1:0];
      x       <= (in_sample > SAMPLE_ONE) ? SAMPLE_ONE : in_sample;
      rd_data <= mem[in_ch_ext[IDX_W-1:0]];
    end
    if (out_load) begin
      mem[idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (accept) rd_vld <= ent_vld[in_ch_ext[IDX_W-1:0]];
      if (out_load) ent_vld[idx] <= 1'b1;
    end
  end

  assign hist = rd_vld ? rd_data : '0;

  always_comb begin
    wr_data.prev_input   = x;
    wr_data.older_input  = hist.prev_input;
    wr_data.prev_output  = y;
    wr_data.older_output = hist.prev_output;
  end

  always_comb begin
    case (cnt)
      3'd0: begin
        coef_sel = coef_b0;
        op_sel   = signed'({1'b0, x});
      end
      3'd1: begin
        coef_sel = coef_b1;
        op_sel   = signed'({1'b0, hist.prev_input});
      end
      3'd2: begin
        coef_sel = coef_b2;
        op_sel   = signed'({1'b0, hist.older_input});
      end
      3'd3: begin
        coef_sel = coef_a1;
        op_sel   = hist.prev_output;
      end
      3'd4: begin
        coef_sel = coef_a2;
        op_sel   = hist.older_output;
      end
      default: begin
        coef_sel = '0;
        op_sel   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt <= '0;
    end else if (state == ST_MUL) begin
      cnt <= cnt + 3'd1;
    end
    prod     <= PROD_W'(coef_sel) * PROD_W'(op_sel);
    prod_sub <= cnt >= 3'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= state == ST_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= prod_sub ? acc - ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  assign acc_rnd = acc + ACC_W'(64'sd2097152);
  assign q       = acc_rnd[ACC_W-1:22];

  always_comb begin
    if (q > (ACC_W - 22)'(OUT_MAX)) begin
      y_next = OUT_MAX;
    end else if (q < (ACC_W - 22)'(OUT_MIN)) begin
      y_next = OUT_MIN;
    end else begin
      y_next = q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RND) y <= y_next;
    if (state == ST_SQR) sq <= SQ_W'(y) * SQ_W'(y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel <= ch;
      filtered    <= y;
      amplitude   <= amp_of(sq);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {amplitude, filtered, out_channel};

endmodule

// ===== design/mbe_chk.sv =====
module mbe_chk #(
  parameter int CHANNELS = mbe_pkg::CHANNELS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [mbe_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import mbe_pkg::*;

  logic [CH_W-1:0]         chk_channel;
  logic signed [OUT_W-1:0] chk_filtered;
  logic [AMP_W-1:0]        chk_amplitude;
  logic signed [SQ_W-1:0]  chk_sq;

  assign chk_channel   = m_axis_tdata[CH_W-1:0];
  assign chk_filtered  = m_axis_tdata[CH_W+OUT_W-1:CH_W];
  assign chk_amplitude = m_axis_tdata[CH_W+OUT_W+AMP_W-1:CH_W+OUT_W];
  assign chk_sq        = SQ_W'(chk_filtered) * SQ_W'(chk_filtered);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_amp_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> chk_amplitude == amp_of(chk_sq))
    else $error("amplitude does not match filtered value");

  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 7'(chk_channel) < 7'(CHANNELS))
    else $error("result for channel out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind multichannel_biquad_envelope_top mbe_chk #(.CHANNELS(CHANNELS)) u_mbe_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/tb_multichannel_biquad_envelope_top.sv =====
`timescale 1ns / 100ps

module tb_multichannel_biquad_envelope_top;
  import mbe_pkg::*;

  localparam int CHANNELS       = CHANNELS_DEF;
  localparam int HALF_PERIOD    = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int LONG_HOLD      = 300;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [COEF_W-1:0] COEF_ONE = 26'h0400000;
  localparam logic [COEF_W-1:0] COEF_HI  = 26'h1FFFFFF;
  localparam logic [COEF_W-1:0] COEF_LO  = 26'h2000000;
  localparam logic [COEF_W-1:0] COEF_ZERO = '0;

  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC} rx_style_t;

  typedef struct {
    logic        [CH_W-1:0]  ch;
    logic signed [OUT_W-1:0] filtered;
    logic        [AMP_W-1:0] amp;
  } envelope_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_DATA_W-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_DATA_W-1:0]  m_axis_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  longint gain_b0 = 0;
  longint gain_b1 = 0;
  longint gain_b2 = 0;
  longint gain_a1 = 0;
  longint gain_a2 = 0;
  longint x_prev[CHANNELS]  = '{default: 0};
  longint x_older[CHANNELS] = '{default: 0};
  longint y_prev[CHANNELS]  = '{default: 0};
  longint y_older[CHANNELS] = '{default: 0};

  logic [S_DATA_W-1:0] samples_to_send[$];
  envelope_t           envelopes_due[$];
  int                  samples_queued = 0;
  int                  samples_taken  = 0;
  int                  mismatches     = 0;
  int                  stalled_cycles = 0;
  logic                took_item      = 1'b0;

  int        burst_left   = 0;
  int        gap_left     = 0;
  int        hold_left    = 0;
  bit        hold_request = 1'b0;
  int        style_left   = 0;
  int        rx_tick      = 0;
  rx_style_t rx_style     = RX_OPEN;

  multichannel_biquad_envelope_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic void apply_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    longint c;
    c = longint'($signed(data));
    case (idx)
      REG_B0: gain_b0 = c;
      REG_B1: gain_b1 = c;
      REG_B2: gain_b2 = c;
      REG_A1: gain_a1 = c;
      REG_A2: gain_a2 = c;
      default: ;
    endcase
  endfunction

  function automatic bit biquad_step(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] raw,
                                     output envelope_t r);
    longint x;
    longint acc;
    longint y;
    longint amp;
    int     c;
    r = '{default: '0};
    c = int'(ch);
    if (c >= CHANNELS) begin
      return 1'b0;
    end
    x = (raw > SAMPLE_ONE) ? longint'(SAMPLE_ONE) : longint'(raw);
    acc = gain_b0 * x + gain_b1 * x_prev[c] + gain_b2 * x_older[c]
        - gain_a1 * y_prev[c] - gain_a2 * y_older[c];
    y = (acc + (longint'(1) << 21)) >>> 22;
    if (y > longint'(OUT_MAX)) y = longint'(OUT_MAX);
    if (y < longint'(OUT_MIN)) y = longint'(OUT_MIN);
    x_older[c] = x_prev[c];
    x_prev[c]  = x;
    y_older[c] = y_prev[c];
    y_prev[c]  = y;
    amp = (y * y + (longint'(1) << 17)) >> 18;
    if (amp > longint'(AMP_MAX)) amp = longint'(AMP_MAX);
    r.ch       = ch;
    r.filtered = OUT_W'(y);
    r.amp      = AMP_W'(amp);
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    envelope_t               want;
    logic        [CH_W-1:0]  got_ch;
    logic signed [OUT_W-1:0] got_y;
    logic        [AMP_W-1:0] got_amp;
    if (rst) begin
      took_item <= 1'b0;
      stalled_cycles = 0;
    end else begin
      if (cfg_we) apply_coef(cfg_index, cfg_data);
      took_item <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        samples_taken++;
        if (biquad_step(s_axis_tdata[CH_W-1:0], s_axis_tdata[CH_W +: SAMPLE_W], want)) begin
          envelopes_due.push_back(want);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_ch  = m_axis_tdata[CH_W-1:0];
        got_y   = m_axis_tdata[CH_W +: OUT_W];
        got_amp = m_axis_tdata[CH_W + OUT_W +: AMP_W];
        if (envelopes_due.size() == 0) begin
          report_mismatch("unexpected item, channel", longint'(got_ch), -1);
        end else begin
          want = envelopes_due.pop_front();
          if (got_ch != want.ch) begin
            report_mismatch("out_channel", longint'(got_ch), longint'(want.ch));
          end
          if (got_y != want.filtered) begin
            report_mismatch("filtered", longint'(got_y), longint'(want.filtered));
          end
          if (got_amp != want.amp) begin
            report_mismatch("amplitude", longint'(got_amp), longint'(want.amp));
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    logic                next_valid;
    logic [S_DATA_W-1:0] next_data;
    next_valid = s_axis_tvalid;
    next_data  = s_axis_tdata;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!s_axis_tvalid || took_item) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (samples_to_send.size() > 0) begin
        next_data  = samples_to_send.pop_front();
        next_valid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    s_axis_tvalid <= next_valid;
    s_axis_tdata  <= next_data;
  end

  always @(negedge clk) begin
    logic next_ready;
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (style_left == 0) begin
      rx_style   = rx_style_t'($urandom_range(0, 2));
      style_left = $urandom_range(16, 96);
    end else begin
      style_left--;
    end
    rx_tick++;
    if (rst) begin
      next_ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else begin
      case (rx_style)
        RX_OPEN:  next_ready = 1'b1;
        RX_COIN:  next_ready = 1'($urandom_range(0, 1));
        default:  next_ready = (rx_tick % 8) >= 3;
      endcase
    end
    m_axis_tready <= next_ready;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_coefs(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                             logic [COEF_W-1:0] b2, logic [COEF_W-1:0] a1,
                             logic [COEF_W-1:0] a2);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
  endtask

  task automatic queue_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] s);
    samples_to_send.push_back({{(S_DATA_W - SAMPLE_W - CH_W){1'b0}}, s, ch});
    samples_queued++;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_W'($urandom);
      1:       return SAMPLE_ONE;
      2:       return '0;
      default: return SAMPLE_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 3))
      0:       return COEF_W'($urandom);
      1:       return COEF_W'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
      2:       return $urandom_range(0, 1) ? COEF_HI : COEF_LO;
      default: return COEF_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  task automatic queue_random(int n);
    int              made;
    int              len;
    int              level;
    logic [CH_W-1:0] ch;
    made = 0;
    while (made < n) begin
      ch = CH_W'($urandom_range(0, CHANNELS - 1));
      if ($urandom_range(0, 3) == 0) begin
        queue_sample(CH_W'($urandom), rand_sample());
        made++;
      end else begin
        len   = $urandom_range(4, 24);
        level = $urandom_range(0, 65536);
        repeat (len) begin
          level += int'($urandom_range(0, 8192)) - 4096;
          if (level < 0) level = 0;
          if (level > 65536) level = 65536;
          queue_sample(ch, ($urandom_range(0, 15) == 0) ? rand_sample() : SAMPLE_W'(level));
          made++;
        end
      end
    end
  endtask

  task automatic settle();
    while (samples_taken != samples_queued || envelopes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_B0;
    cfg_data      = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // passthrough, clamping of samples above one, spare indexes ignored
    write_coefs(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    for (int i = int'(REG_SPARE_LO); i <= int'(REG_SPARE_HI); i++) begin
      write_reg(CFG_IDX_W'(i), COEF_HI);
    end
    queue_sample(CH_W'(0), SAMPLE_W'(0));
    queue_sample(CH_W'(31), SAMPLE_ONE);
    queue_sample(CH_W'(5), SAMPLE_W'(131071));
    queue_sample(CH_W'(5), SAMPLE_W'(65537));
    queue_sample(CH_W'(1), SAMPLE_W'(1));
    queue_sample(CH_W'(2), SAMPLE_W'(32768));
    queue_sample(CH_W'(9), SAMPLE_W'(65535));
    settle();

    // drive to positive saturation through feedback
    write_coefs(COEF_HI, COEF_HI, COEF_HI, COEF_LO, COEF_LO);
    repeat (5) queue_sample(CH_W'(3), SAMPLE_ONE);
    queue_sample(CH_W'(3), SAMPLE_W'(0));
    settle();

    // drive to negative saturation
    write_coefs(COEF_LO, COEF_LO, COEF_LO, COEF_HI, COEF_HI);
    repeat (5) queue_sample(CH_W'(4), SAMPLE_ONE);
    queue_sample(CH_W'(31), SAMPLE_W'(0));
    settle();

    // stable low-pass
    write_coefs(COEF_W'(283116), COEF_W'(566232), COEF_W'(283116),
                COEF_W'(-4794164), COEF_W'(1731445));
    queue_random(150);
    settle();
    queue_random(60);
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    queue_random(90);
    settle();

    repeat (4) begin
      write_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
      queue_random(150);
      settle();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
